FILE: sv/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg: shared definitions for the k-means cluster engine
// Sizes, store address widths, command and register codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmc_pkg;

	localparam int MAX_POINTS  = 1024;
	localparam int MAX_DIMS    = 8;
	localparam int MAX_CENTRES = 16;
	localparam int VALUE_BITS  = 16;
	localparam int MAX_ITERS   = 255;

	localparam int PIDX_W = $clog2(MAX_POINTS);
	localparam int DIDX_W = $clog2(MAX_DIMS);
	localparam int CIDX_W = $clog2(MAX_CENTRES);
	localparam int PT_AW  = PIDX_W + DIDX_W;
	localparam int CT_AW  = CIDX_W + DIDX_W;

	localparam int DIST_W  = 35;
	localparam int ERR_W   = 45;
	localparam int SUM_W   = 26;
	localparam int CNT_W   = 11;
	localparam int ITER_W  = 8;
	localparam int ASN_W   = CIDX_W + DIST_W;
	localparam int DIFF_W  = VALUE_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 11;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_SEED  = 2'd1,
		ACT_START = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_COUNT  = 2'd0,
		REG_DIM_COUNT    = 2'd1,
		REG_CENTRE_COUNT = 2'd2,
		REG_ITER_LIMIT   = 2'd3
	} reg_index_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_SEED,
		ST_READ,
		ST_CLR,
		ST_DIST,
		ST_DWAIT,
		ST_ASGN,
		ST_ACC,
		ST_AWAIT,
		ST_UPD_C,
		ST_UPD_RD,
		ST_UPD_WT,
		ST_UPD_DIV,
		ST_UPD_WR,
		ST_CHECK,
		ST_SUM
	} state_t;

endpackage

FILE: sv/kmc_ram.sv
// ----------------------------------------------------------------------------
// kmc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (valid in the cycle after the read address).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/kmc_div.sv
// ----------------------------------------------------------------------------
// kmc_div: restoring unsigned divider for the centre mean
// Produces one quotient bit per cycle; done pulses when the quotient is valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [kmc_pkg::SUM_W-1:0] dividend,
	input  logic [kmc_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [kmc_pkg::SUM_W-1:0] quotient
);

	import kmc_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	always_comb begin
		trial = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend register doubles as the quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: sv/kmeans_lloyd_cluster.sv
// ----------------------------------------------------------------------------
// kmeans_lloyd_cluster: Lloyd k-means engine over host-loaded Q1.15 points
// Point, centre, partial-sum and assignment stores in RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// The host loads point coordinates one beat at a time (action load), seeds
// each centre by copying a point row (action seed), then issues start. A run
// repeats: clear the per-centre sums, assign every point to its nearest
// centre by squared distance (lowest index wins ties), then move each
// non-empty centre to the mean of its members, truncated toward zero. It stops
// from the third iteration on when no centre moved and the total error is
// unchanged, or at iteration_limit, and returns one summary beat. A read beat
// returns a point's cluster and squared distance. A load leaves the block idle
// and ready for the next beat. In a run the distance walk is bound by the
// single read port of the point and centre RAMs, and the centre update by
// the bit-serial divider. After reset the assignment RAM is cleared, one row
// a cycle, over all 1024 rows; input beats are not accepted during that time.
// Config writes are always accepted and must only be issued while the block
// is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmeans_lloyd_cluster (
	input  logic                          clk,
	input  logic                          arst_n,
	// Config write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kmc_pkg::CFG_DAT_W-1:0] cfg_data,
	// Command stream.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata: point_index[9:0], dim_index[12:10], centre_index[16:13],
	// element_value[32:17], zero fill [39:33]
	input  logic [39:0]                   s_axis_tdata,
	// tuser: action[1:0]
	input  logic [1:0]                    s_axis_tuser,
	// Result stream.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata: cluster[3:0], sq_distance[38:4], total_error[83:39],
	// iterations_used[91:84], converged[92], zero fill [95:93]
	output logic [95:0]                   m_axis_tdata,
	// tuser: is_summary[0]
	output logic                          m_axis_tuser
);

	import kmc_pkg::*;

	// ------------------------------------------------------------------
	// Config registers and their effective (clamped) values
	// ------------------------------------------------------------------
	logic [10:0]       pc_q;
	logic [3:0]        dc_q;
	logic [4:0]        cc_q;
	logic [ITER_W-1:0] lim_q;
	logic [10:0]       np;
	logic [3:0]        nd;
	logic [4:0]        nc;
	logic [ITER_W-1:0] lim;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= 11'(MAX_POINTS);
			dc_q  <= 4'(MAX_DIMS);
			cc_q  <= 5'd2;
			lim_q <= 8'd100;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_POINT_COUNT:  pc_q  <= cfg_data;
				REG_DIM_COUNT:    dc_q  <= cfg_data[3:0];
				REG_CENTRE_COUNT: cc_q  <= cfg_data[4:0];
				REG_ITER_LIMIT:   lim_q <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		np  = (pc_q == '0) ? 11'd1 : ((pc_q > 11'(MAX_POINTS)) ? 11'(MAX_POINTS) : pc_q);
		nd  = (dc_q == '0) ? 4'd1 : ((dc_q > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : dc_q);
		nc  = (cc_q == '0) ? 5'd1 : ((cc_q > 5'(MAX_CENTRES)) ? 5'(MAX_CENTRES) : cc_q);
		lim = (lim_q == '0) ? 8'd1 : lim_q;
	end

	// ------------------------------------------------------------------
	// Input beat fields
	// ------------------------------------------------------------------
	logic [PIDX_W-1:0]     in_pi;
	logic [DIDX_W-1:0]     in_di;
	logic [CIDX_W-1:0]     in_ci;
	logic [VALUE_BITS-1:0] in_ev;
	action_t               in_act;
	logic                  in_acc;

	assign in_pi  = s_axis_tdata[9:0];
	assign in_di  = s_axis_tdata[12:10];
	assign in_ci  = s_axis_tdata[16:13];
	assign in_ev  = s_axis_tdata[32:17];
	assign in_act = action_t'(s_axis_tuser);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------
	// Sequencer state and counters
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	logic [10:0]       k_q;
	logic [10:0]       p_q;
	logic [4:0]        c_q;
	logic [3:0]        d_q;
	logic [PIDX_W-1:0] pi_q;
	logic [CIDX_W-1:0] ci_q;
	logic [ITER_W-1:0] iter_q;
	logic [ERR_W-1:0]  err_q;
	logic [ERR_W-1:0]  old_err_q;
	logic              moved_q;
	logic              conv_q;
	logic [CIDX_W-1:0] best_q;
	logic [DIST_W-1:0] bestd_q;
	logic [DIST_W-1:0] acc_q;
	logic [CNT_W-1:0]  mc_q [MAX_CENTRES];

	// Distance pipeline.
	logic                     rv_s1, last_s1;
	logic                     v_s2, last_s2;
	logic [PROD_W-1:0]        prod_s2;
	// Partial-sum accumulate pipeline.
	logic                     acc_v_s1, acc_last_s1;
	logic [CT_AW-1:0]         acc_addr_s1;
	// Centre update operands.
	logic                     neg_q;
	logic [VALUE_BITS-1:0]    old_c_q;

	// Output slot.
	logic        out_valid_q;
	logic        out_user_q;
	logic [95:0] out_data_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || m_axis_tready;

	// RAM ports.
	logic                  pt_we;
	logic [PT_AW-1:0]      pt_waddr, pt_raddr;
	logic [VALUE_BITS-1:0] pt_wdata, pt_rdata;
	logic                  ct_we;
	logic [CT_AW-1:0]      ct_waddr, ct_raddr;
	logic [VALUE_BITS-1:0] ct_wdata, ct_rdata;
	logic                  cs_we;
	logic [CT_AW-1:0]      cs_waddr, cs_raddr;
	logic [SUM_W-1:0]      cs_wdata, cs_rdata;
	logic                  as_we;
	logic [PIDX_W-1:0]     as_waddr, as_raddr;
	logic [ASN_W-1:0]      as_wdata, as_rdata;

	// Divider.
	logic             div_start, div_done;
	logic [SUM_W-1:0] div_quot, sum_abs;
	logic [VALUE_BITS-1:0] mean;

	// Step flags shared by next-state and datapath.
	logic              d_last;
	logic              dist_done;
	logic [DIST_W-1:0] dist_total;
	logic              take_best;
	logic              more_c, more_p;
	logic [ITER_W-1:0] used;
	logic              stop_conv;

	always_comb begin
		d_last     = (d_q == nd - 4'd1);
		dist_done  = v_s2 && last_s2;
		dist_total = acc_q + DIST_W'(prod_s2[31:0]);
		take_best  = (c_q == '0) || (dist_total < bestd_q);
		more_c     = (c_q + 5'd1) < nc;
		more_p     = (p_q + 11'd1) < np;
		used       = iter_q + 8'd1;
		stop_conv  = (iter_q > 8'd1) && !moved_q && (err_q == old_err_q);
		sum_abs    = cs_rdata[SUM_W-1] ? (SUM_W'(0) - cs_rdata) : cs_rdata;
		mean       = neg_q ? (VALUE_BITS'(0) - div_quot[VALUE_BITS-1:0])
		                   : div_quot[VALUE_BITS-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:    if (k_q == 11'(MAX_POINTS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc) begin
					case (in_act)
						ACT_SEED:  state_d = ST_SEED;
						ACT_START: state_d = ST_CLR;
						ACT_READ:  state_d = ST_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEED:    if (k_q == 11'(MAX_DIMS)) state_d = ST_IDLE;
			ST_READ:    if (slot_free) state_d = ST_IDLE;
			ST_CLR:     if (k_q == 11'(MAX_CENTRES * MAX_DIMS - 1)) state_d = ST_DIST;
			ST_DIST:    if (d_last) state_d = ST_DWAIT;
			ST_DWAIT:   if (dist_done) state_d = more_c ? ST_DIST : ST_ASGN;
			ST_ASGN:    state_d = ST_ACC;
			ST_ACC:     if (d_last) state_d = ST_AWAIT;
			ST_AWAIT:   if (acc_v_s1 && acc_last_s1) state_d = more_p ? ST_DIST : ST_UPD_C;
			ST_UPD_C: begin
				if (c_q >= nc) state_d = ST_CHECK;
				else if (mc_q[c_q[CIDX_W-1:0]] != '0) state_d = ST_UPD_RD;
			end
			ST_UPD_RD:  state_d = ST_UPD_WT;
			ST_UPD_WT:  state_d = ST_UPD_DIV;
			ST_UPD_DIV: if (div_done) state_d = ST_UPD_WR;
			ST_UPD_WR:  state_d = d_last ? ST_UPD_C : ST_UPD_RD;
			ST_CHECK:   state_d = (stop_conv || used >= lim) ? ST_SUM : ST_CLR;
			ST_SUM:     if (slot_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign div_start     = (state_q == ST_UPD_WT);

	// ------------------------------------------------------------------
	// RAM port steering
	// ------------------------------------------------------------------
	always_comb begin
		pt_we    = in_acc && (in_act == ACT_LOAD);
		pt_waddr = {in_pi, in_di};
		pt_wdata = in_ev;
		pt_raddr = {p_q[PIDX_W-1:0], d_q[DIDX_W-1:0]};
		if (state_q == ST_SEED) begin
			pt_raddr = {pi_q, k_q[DIDX_W-1:0]};
		end

		ct_we    = 1'b0;
		ct_waddr = {c_q[CIDX_W-1:0], d_q[DIDX_W-1:0]};
		ct_wdata = mean;
		ct_raddr = {c_q[CIDX_W-1:0], d_q[DIDX_W-1:0]};
		if (state_q == ST_SEED && k_q != '0) begin
			ct_we    = 1'b1;
			ct_waddr = {ci_q, DIDX_W'(k_q - 11'd1)};
			ct_wdata = pt_rdata;
		end else if (state_q == ST_UPD_WR) begin
			ct_we = 1'b1;
		end

		cs_we    = 1'b0;
		cs_waddr = acc_addr_s1;
		cs_wdata = cs_rdata + SUM_W'(signed'(pt_rdata));
		cs_raddr = {c_q[CIDX_W-1:0], d_q[DIDX_W-1:0]};
		if (state_q == ST_ACC) begin
			cs_raddr = {best_q, d_q[DIDX_W-1:0]};
		end
		if (state_q == ST_CLR) begin
			cs_we    = 1'b1;
			cs_waddr = k_q[CT_AW-1:0];
			cs_wdata = '0;
		end else if (acc_v_s1) begin
			cs_we = 1'b1;
		end

		as_we    = 1'b0;
		as_waddr = p_q[PIDX_W-1:0];
		as_wdata = {best_q, bestd_q};
		as_raddr = (state_q == ST_IDLE) ? in_pi : pi_q;
		if (state_q == ST_INIT) begin
			as_we    = 1'b1;
			as_waddr = k_q[PIDX_W-1:0];
			as_wdata = '0;
		end else if (state_q == ST_ASGN) begin
			as_we = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Datapath and counters
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			p_q         <= '0;
			c_q         <= '0;
			d_q         <= '0;
			rv_s1       <= 1'b0;
			last_s1     <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			acc_v_s1    <= 1'b0;
			acc_last_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			iter_q      <= '0;
			moved_q     <= 1'b0;
			conv_q      <= 1'b0;
			for (int i = 0; i < MAX_CENTRES; i++) begin
				mc_q[i] <= '0;
			end
		end else begin
			k_q <= (state_d != state_q) ? 11'd0 : k_q + 11'd1;

			rv_s1       <= (state_q == ST_DIST);
			last_s1     <= (state_q == ST_DIST) && d_last;
			v_s2        <= rv_s1;
			last_s2     <= last_s1;
			acc_v_s1    <= (state_q == ST_ACC);
			acc_last_s1 <= (state_q == ST_ACC) && d_last;

			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_act == ACT_START) begin
						iter_q <= '0;
						conv_q <= 1'b0;
					end
				end
				ST_READ: if (slot_free) out_valid_q <= 1'b1;
				ST_CLR: begin
					p_q     <= '0;
					c_q     <= '0;
					d_q     <= '0;
					moved_q <= 1'b0;
					for (int i = 0; i < MAX_CENTRES; i++) begin
						mc_q[i] <= '0;
					end
				end
				ST_DIST: d_q <= d_q + 4'd1;
				ST_DWAIT: begin
					if (dist_done) begin
						d_q <= '0;
						if (more_c) c_q <= c_q + 5'd1;
					end
				end
				ST_ASGN: begin
					mc_q[best_q] <= mc_q[best_q] + 11'd1;
				end
				ST_ACC: d_q <= d_q + 4'd1;
				ST_AWAIT: begin
					if (acc_v_s1 && acc_last_s1) begin
						c_q <= '0;
						d_q <= '0;
						if (more_p) p_q <= p_q + 11'd1;
					end
				end
				ST_UPD_C: begin
					d_q <= '0;
					if (c_q < nc && mc_q[c_q[CIDX_W-1:0]] == '0) c_q <= c_q + 5'd1;
				end
				ST_UPD_WR: begin
					if (mean != old_c_q) moved_q <= 1'b1;
					if (d_last) begin
						d_q <= '0;
						c_q <= c_q + 5'd1;
					end else begin
						d_q <= d_q + 4'd1;
					end
				end
				ST_CHECK: begin
					if (stop_conv) begin
						conv_q <= 1'b1;
					end else if (used < lim) begin
						iter_q <= used;
					end
				end
				ST_SUM: if (slot_free) out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(($signed({pt_rdata[VALUE_BITS-1], pt_rdata})
		          - $signed({ct_rdata[VALUE_BITS-1], ct_rdata}))
		          * ($signed({pt_rdata[VALUE_BITS-1], pt_rdata})
		          - $signed({ct_rdata[VALUE_BITS-1], ct_rdata})));
		acc_addr_s1 <= {best_q, d_q[DIDX_W-1:0]};

		if (v_s2) begin
			acc_q <= last_s2 ? '0 : dist_total;
		end
		if (state_q == ST_CLR) begin
			acc_q <= '0;
			err_q <= '0;
		end
		if (dist_done && take_best) begin
			bestd_q <= dist_total;
			best_q  <= c_q[CIDX_W-1:0];
		end
		if (state_q == ST_ASGN) begin
			err_q <= err_q + ERR_W'(bestd_q);
		end
		if (state_q == ST_UPD_WT) begin
			neg_q   <= cs_rdata[SUM_W-1];
			old_c_q <= ct_rdata;
		end
		if (state_q == ST_IDLE && in_acc) begin
			pi_q <= in_pi;
			ci_q <= in_ci;
			if (in_act == ACT_START) begin
				old_err_q <= '0;
			end
		end
		if (state_q == ST_CHECK && !stop_conv) begin
			old_err_q <= err_q;
		end
		if (state_q == ST_READ && slot_free) begin
			out_user_q <= 1'b0;
			out_data_q <= {57'd0, as_rdata[DIST_W-1:0], as_rdata[ASN_W-1:DIST_W]};
		end
		if (state_q == ST_SUM && slot_free) begin
			out_user_q <= 1'b1;
			out_data_q <= {3'd0, conv_q, used, err_q, 39'd0};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tdata  = out_data_q;

	// ------------------------------------------------------------------
	// Stores and divider
	// ------------------------------------------------------------------
	kmc_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_POINTS * MAX_DIMS)) u_point_ram (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	kmc_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_CENTRES * MAX_DIMS)) u_centre_ram (
		.clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
		.raddr(ct_raddr), .rdata(ct_rdata)
	);

	kmc_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CENTRES * MAX_DIMS)) u_sum_ram (
		.clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
		.raddr(cs_raddr), .rdata(cs_rdata)
	);

	kmc_ram #(.WIDTH(ASN_W), .DEPTH(MAX_POINTS)) u_assign_ram (
		.clk(clk), .we(as_we), .waddr(as_waddr), .wdata(as_wdata),
		.raddr(as_raddr), .rdata(as_rdata)
	);

	kmc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(sum_abs), .divisor(mc_q[c_q[CIDX_W-1:0]]),
		.done(div_done), .quotient(div_quot)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_acc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		acc_v_s1 |-> (state_q == ST_ACC || state_q == ST_AWAIT))
		else $error("partial-sum write outside the accumulate phase");

	a_div_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_UPD_DIV))
		else $error("divider finished outside the update step");

	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ASGN) |-> ({1'b0, best_q} < nc))
		else $error("assigned centre beyond centre count");

	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[38:0] == '0))
		else $error("summary beat carries point fields");

endmodule

FILE: tb/tb_kmeans_lloyd_cluster.sv
// ----------------------------------------------------------------------------
// tb_kmeans_lloyd_cluster: self-checking bench for the Lloyd k-means engine
// Loads points, seeds centres, starts runs and reads points back. A built-in
// predictor computes every summary and read beat, and a monitor compares
// each output beat field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_kmeans_lloyd_cluster;

	import kmc_pkg::*;

	// Cycles without any accepted beat before the run is declared hung.
	localparam int HANG_LIMIT = 2000000;
	// Quiet cycles after the last result before a register write; a seed may
	// still be copying its row when nothing is expected any more.
	localparam int SETTLE_CYCLES = 24;
	localparam int NUM_PHASES = 7;

	typedef struct {
		action_t    act;
		logic [9:0] row;
		logic [2:0] dim;
		logic [3:0] centre;
		logic [15:0] value;
		bit         hold;
	} command_t;

	typedef struct {
		bit               is_summary;
		logic [3:0]       cluster;
		logic [DIST_W-1:0] sq_distance;
		logic [ERR_W-1:0] total_error;
		logic [7:0]       iterations;
		bit               converged;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic m_axis_tuser;

	kmeans_lloyd_cluster dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the block: stores, last assignment per row, register values.
	shortint     point_mem [MAX_POINTS][MAX_DIMS];
	shortint     centre_mem [MAX_CENTRES][MAX_DIMS];
	logic [3:0]  row_cluster [MAX_POINTS];
	logic [DIST_W-1:0] row_distance [MAX_POINTS];
	int unsigned reg_points = 1024;
	int unsigned reg_dims = 8;
	int unsigned reg_centres = 2;
	int unsigned reg_limit = 100;

	command_t pending_cmds[$];
	outcome_t expected_beats[$];
	command_t cur_cmd;

	int send_idle_pct = 31;
	int recv_idle_pct = 85;
	int mismatches = 0;
	int beats_checked = 0;
	int runs_checked = 0;
	int reads_checked = 0;
	int idle_cycles = 0;
	int converged_runs = 0;

	initial begin
		foreach (point_mem[p, d]) point_mem[p][d] = 0;
		foreach (centre_mem[c, d]) centre_mem[c][d] = 0;
		foreach (row_cluster[p]) begin
			row_cluster[p] = '0;
			row_distance[p] = '0;
		end
	end

	// Zero reads as one; anything above the maximum saturates.
	function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic longint unsigned point_to_centre(int p, int c, int nd);
		longint unsigned acc;
		longint diff;
		acc = 0;
		for (int d = 0; d < nd; d++) begin
			diff = longint'(point_mem[p][d]) - longint'(centre_mem[c][d]);
			acc += longint'(diff * diff);
		end
		return acc;
	endfunction

	// One whole start: Lloyd iterations until the limit or a stable state.
	function automatic outcome_t run_lloyd();
		outcome_t r;
		int unsigned np, nd, nc, lim, used;
		longint unsigned err, old_err, bd, v;
		longint sums [MAX_CENTRES][MAX_DIMS];
		int counts [MAX_CENTRES];
		int best;
		shortint nv;
		bit moved, conv;
		np = clamp_reg(reg_points, MAX_POINTS);
		nd = clamp_reg(reg_dims, MAX_DIMS);
		nc = clamp_reg(reg_centres, MAX_CENTRES);
		lim = clamp_reg(reg_limit, MAX_ITERS);
		old_err = 0;
		err = 0;
		used = 0;
		conv = 0;
		for (int n = 0; n < lim; n++) begin
			moved = 0;
			err = 0;
			foreach (sums[c, d]) sums[c][d] = 0;
			foreach (counts[c]) counts[c] = 0;
			for (int p = 0; p < np; p++) begin
				best = 0;
				bd = point_to_centre(p, 0, nd);
				for (int c = 1; c < nc; c++) begin
					v = point_to_centre(p, c, nd);
					if (v < bd) begin
						bd = v;
						best = c;
					end
				end
				row_cluster[p] = best[3:0];
				row_distance[p] = bd[DIST_W-1:0];
				err += bd;
				counts[best]++;
				for (int d = 0; d < nd; d++) sums[best][d] += point_mem[p][d];
			end
			for (int c = 0; c < nc; c++) begin
				if (counts[c] != 0) begin
					for (int d = 0; d < nd; d++) begin
						// SystemVerilog division truncates toward zero.
						nv = shortint'(sums[c][d] / longint'(counts[c]));
						if (nv != centre_mem[c][d]) moved = 1;
						centre_mem[c][d] = nv;
					end
				end
			end
			used = n + 1;
			if (n > 1 && !moved && err == old_err) begin
				conv = 1;
				break;
			end
			old_err = err;
		end
		r.is_summary = 1;
		r.cluster = '0;
		r.sq_distance = '0;
		r.total_error = err[ERR_W-1:0];
		r.iterations = used[7:0];
		r.converged = conv;
		return r;
	endfunction

	// Applies one accepted command to the shadow and queues what it causes.
	task automatic apply_command(command_t cmd);
		outcome_t r;
		case (cmd.act)
			ACT_LOAD: begin
				point_mem[cmd.row][cmd.dim] = shortint'(cmd.value);
			end
			ACT_SEED: begin
				for (int d = 0; d < MAX_DIMS; d++) centre_mem[cmd.centre][d] = point_mem[cmd.row][d];
			end
			ACT_START: begin
				r = run_lloyd();
				expected_beats.push_back(r);
			end
			default: begin
				r.is_summary = 0;
				r.cluster = row_cluster[cmd.row];
				r.sq_distance = row_distance[cmd.row];
				r.total_error = '0;
				r.iterations = '0;
				r.converged = 0;
				expected_beats.push_back(r);
			end
		endcase
	endtask

	// Command driver: one beat in flight, refilled from the pending queue.
	always @(posedge clk) begin
		bit busy;
		if (arst_n) begin
			busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				apply_command(cur_cmd);
				busy = 0;
			end
			if (!busy) begin
				if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
				    !(pending_cmds[0].hold && expected_beats.size() > 0)) begin
					cur_cmd = pending_cmds.pop_front();
					s_axis_tdata <= {7'd0, cur_cmd.value, cur_cmd.centre, cur_cmd.dim, cur_cmd.row};
					s_axis_tuser <= cur_cmd.act;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		mismatches++;
		$display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
	endtask

	// Result monitor: every output beat against the oldest expectation.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("unexpected beat", m_axis_tdata[63:0], 0);
			end else begin
				e = expected_beats.pop_front();
				beats_checked++;
				if (e.is_summary) runs_checked++;
				else reads_checked++;
				if (e.is_summary && e.converged) converged_runs++;
				if (m_axis_tuser !== e.is_summary) report_mismatch("is_summary", m_axis_tuser, e.is_summary);
				if (m_axis_tdata[3:0] !== e.cluster) report_mismatch("cluster", m_axis_tdata[3:0], e.cluster);
				if (m_axis_tdata[38:4] !== e.sq_distance)
					report_mismatch("sq_distance", m_axis_tdata[38:4], e.sq_distance);
				if (m_axis_tdata[83:39] !== e.total_error)
					report_mismatch("total_error", m_axis_tdata[83:39], e.total_error);
				if (m_axis_tdata[91:84] !== e.iterations)
					report_mismatch("iterations_used", m_axis_tdata[91:84], e.iterations);
				if (m_axis_tdata[92] !== e.converged) report_mismatch("converged", m_axis_tdata[92], e.converged);
			end
		end
	end

	// Hang detector: any accepted beat on any channel restarts the count.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("timeout: no beat accepted for %0d cycles", HANG_LIMIT);
				$display("kmeans_lloyd_cluster test failed");
				$finish;
			end
		end
	end

	// Stimulus-side bookkeeping so that no start or seed touches an unwritten entry.
	logic [7:0] written_dims [MAX_POINTS];
	bit seeded [MAX_CENTRES];
	int full_rows[$];

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_cmd(action_t act, int row, int dim, int centre, logic [15:0] value, bit hold);
		command_t c;
		c.act = act;
		c.row = row[9:0];
		c.dim = dim[2:0];
		c.centre = centre[3:0];
		c.value = value;
		c.hold = hold;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_load(int row, int dim, logic [15:0] value);
		queue_cmd(ACT_LOAD, row, dim, 0, value, 0);
		if (written_dims[row] != 8'hFF) begin
			written_dims[row][dim] = 1'b1;
			if (written_dims[row] == 8'hFF) full_rows.push_back(row);
		end
	endtask

	task automatic queue_seed(int centre, int row);
		queue_cmd(ACT_SEED, row, 0, centre, 16'h0, 0);
		seeded[centre] = 1;
	endtask

	task automatic wait_quiet();
		while (pending_cmds.size() > 0 || s_axis_tvalid || expected_beats.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DAT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_POINT_COUNT:  reg_points = value;
			REG_DIM_COUNT:    reg_dims = value;
			REG_CENTRE_COUNT: reg_centres = value;
			default:          reg_limit = value;
		endcase
	endtask

	initial begin
		// Raw register values per phase, including zero and over-range writes.
		int unsigned ph_points [NUM_PHASES] = '{0, 8, 16, 12, 2047, 5, 32};
		int unsigned ph_dims [NUM_PHASES] = '{1, 2, 8, 15, 1, 3, 4};
		int unsigned ph_centres [NUM_PHASES] = '{1, 3, 4, 31, 1, 2, 8};
		int unsigned ph_limits [NUM_PHASES] = '{0, 4, 6, 3, 255, 255, 10};
		int np, nd, nc, pick, row;
		foreach (written_dims[r]) written_dims[r] = '0;
		foreach (seeded[c]) seeded[c] = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// Let the post-reset clearing pass finish before touching registers.
		do @(posedge clk); while (!s_axis_tready);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_quiet();
			send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 85 : 0;
			recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 31 : 0;
			write_reg(REG_POINT_COUNT, ph_points[ph]);
			write_reg(REG_DIM_COUNT, ph_dims[ph]);
			write_reg(REG_CENTRE_COUNT, ph_centres[ph]);
			write_reg(REG_ITER_LIMIT, ph_limits[ph]);
			cfg_valid <= 1'b0;
			np = clamp_reg(ph_points[ph], MAX_POINTS);
			nd = clamp_reg(ph_dims[ph], MAX_DIMS);
			nc = clamp_reg(ph_centres[ph], MAX_CENTRES);

			if (ph == 0) begin
				// Directed opening: value extremes, all commands, reads of
				// never-assigned rows, a top-row load and a top-centre seed.
				queue_cmd(ACT_READ, 0, 0, 0, 16'h0, 0);
				queue_cmd(ACT_READ, 1023, 0, 0, 16'h0, 0);
				queue_load(0, 0, 16'h8000);
				queue_load(0, 1, 16'h7FFF);
				queue_load(0, 2, 16'h0000);
				queue_load(0, 3, 16'hFFFF);
				queue_load(0, 4, 16'h0001);
				queue_load(0, 5, 16'h5555);
				queue_load(0, 6, 16'hAAAA);
				queue_load(0, 7, 16'h7FFF);
				queue_load(1023, 7, 16'h8000);
				queue_seed(0, 0);
				queue_seed(15, 0);
				queue_cmd(ACT_START, 0, 0, 0, 16'h0, 0);
				queue_cmd(ACT_READ, 0, 0, 0, 16'h0, 0);
				queue_cmd(ACT_READ, 1023, 0, 0, 16'h0, 0);
				queue_load(0, 0, 16'h7FFF);
				queue_cmd(ACT_START, 0, 0, 0, 16'h0, 1);
				queue_cmd(ACT_READ, 0, 0, 0, 16'h0, 0);
			end

			// Make every row in the run defined over the dims in use, and give
			// every centre in use a full seed row.
			for (int r = 0; r < np; r++)
				for (int d = 0; d < nd; d++)
					if (!written_dims[r][d]) queue_load(r, d, pick_value());
			for (int c = 0; c < nc; c++) begin
				for (int d = 0; d < MAX_DIMS; d++)
					if (!written_dims[c][d]) queue_load(c, d, pick_value());
				if (!seeded[c]) queue_seed(c, c);
			end

			for (int i = 0; i < 110; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					row = ($urandom_range(0, 9) < 7) ? $urandom_range(0, np - 1) : $urandom_range(0, 1023);
					queue_load(row, $urandom_range(0, 7), pick_value());
				end else if (pick < 68) begin
					queue_seed($urandom_range(0, 15), full_rows[$urandom_range(0, full_rows.size() - 1)]);
				end else if (pick < 96) begin
					row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, np - 1);
					queue_cmd(ACT_READ, row, $urandom_range(0, 7), $urandom_range(0, 15), $urandom(), 0);
				end else begin
					// Some starts hold off until every earlier result is out.
					queue_cmd(ACT_START, $urandom_range(0, 1023), 0, 0, $urandom(),
					          $urandom_range(0, 1));
				end
			end
			queue_cmd(ACT_START, 0, 0, 0, 16'h0, 0);
			for (int r = 0; r < 4; r++) queue_cmd(ACT_READ, $urandom_range(0, np - 1), 0, 0, 16'h0, 0);
		end

		wait_quiet();
		repeat (64) @(posedge clk);
		if (expected_beats.size() > 0) report_mismatch("results never delivered", expected_beats.size(), 0);
		$display("covered %0d phases of register settings, %0d runs (%0d converged), %0d reads",
		         NUM_PHASES, runs_checked, converged_runs, reads_checked);
		$display("%0d result beats checked, %0d mismatches", beats_checked, mismatches);
		if (mismatches == 0) begin
			$display("kmeans_lloyd_cluster test passed");
		end else begin
			$display("kmeans_lloyd_cluster test failed");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/kmc_pkg.sv
sv/kmc_ram.sv
sv/kmc_div.sv
sv/kmeans_lloyd_cluster.sv
tb/tb_kmeans_lloyd_cluster.sv
